>>> design/acpu16_pkg.sv
// ----------------------------------------------------------------------------
// acpu16_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package acpu16_pkg;

    localparam int MEM_WORDS = 2048;
    localparam int ADDR_W    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int PC_W      = 13;
    localparam int WORD_W    = 16;
    localparam int OPND_W    = 12;
    localparam int SIZE_W    = 12;
    localparam int IN_ADDR_W = 11;

    localparam logic [PC_W-1:0]   LIM_MAX      = PC_W'(MEM_WORDS);
    localparam logic [SIZE_W-1:0] MEM_SIZE_RST = SIZE_W'(128);

    // item kinds
    localparam logic [1:0] K_LOAD  = 2'd0;
    localparam logic [1:0] K_START = 2'd1;
    localparam logic [1:0] K_EXEC  = 2'd2;
    localparam logic [1:0] K_READ  = 2'd3;

    // run status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_HALTED  = 2'd1;
    localparam logic [1:0] ST_OPERR   = 2'd2;
    localparam logic [1:0] ST_ADDRERR = 2'd3;

    // instruction opcodes
    localparam logic [3:0] OP_LDI  = 4'd0;
    localparam logic [3:0] OP_LD   = 4'd1;
    localparam logic [3:0] OP_LDX  = 4'd2;
    localparam logic [3:0] OP_ST   = 4'd3;
    localparam logic [3:0] OP_STX  = 4'd4;
    localparam logic [3:0] OP_ADD  = 4'd5;
    localparam logic [3:0] OP_SUB  = 4'd6;
    localparam logic [3:0] OP_JMP  = 4'd7;
    localparam logic [3:0] OP_JN   = 4'd8;
    localparam logic [3:0] OP_JZ   = 4'd9;
    localparam logic [3:0] OP_JIND = 4'd10;
    localparam logic [3:0] OP_CALL = 4'd11;
    localparam logic [3:0] OP_HALT = 4'd12;

    // memory address select
    localparam logic [1:0] AS_IN = 2'd0;
    localparam logic [1:0] AS_PC = 2'd1;
    localparam logic [1:0] AS_RD = 2'd2;

    // memory write data select
    localparam logic [1:0] WS_IN  = 2'd0;
    localparam logic [1:0] WS_ACC = 2'd1;
    localparam logic [1:0] WS_PC  = 2'd2;

    // accumulator update
    localparam logic [2:0] ACC_HOLD = 3'd0;
    localparam logic [2:0] ACC_CLR  = 3'd1;
    localparam logic [2:0] ACC_IMM  = 3'd2;
    localparam logic [2:0] ACC_MEM  = 3'd3;
    localparam logic [2:0] ACC_ADD  = 3'd4;
    localparam logic [2:0] ACC_SUB  = 3'd5;

    // program counter update
    localparam logic [2:0] PC_HOLD = 3'd0;
    localparam logic [2:0] PC_CLR  = 3'd1;
    localparam logic [2:0] PC_INC  = 3'd2;
    localparam logic [2:0] PC_OPND = 3'd3;
    localparam logic [2:0] PC_CALL = 3'd4;
    localparam logic [2:0] PC_EFF  = 3'd5;

    typedef struct packed {
        logic       in_load;
        logic       mem_rd;
        logic       mem_wr;
        logic [1:0] addr_sel;
        logic [1:0] wd_sel;
        logic       instr_load;
        logic [2:0] acc_op;
        logic [2:0] pc_op;
        logic       st_we;
        logic [1:0] st_val;
        logic       rd_load;
        logic       fault_set;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       run_ok;
        logic       in_addr_ok;
        logic       pc_ok;
        logic [3:0] fetch_op;
        logic       fetch_opnd_ok;
        logic [3:0] instr_op;
        logic       eff_ok;
        logic       acc_neg;
        logic       acc_zero;
    } stat_t;

endpackage

>>> design/acpu16_dp.sv
// ----------------------------------------------------------------------------
// acpu16_dp
// datapath: word memory, machine registers, item and result registers
// ----------------------------------------------------------------------------
module acpu16_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [11:0]            cfg_wdata,
    input  logic [1:0]             s_tuser,
    input  logic [31:0]            s_tdata,
    input  acpu16_pkg::cmd_t       cmd,
    output acpu16_pkg::stat_t      stat,
    output logic [47:0]            m_tdata
);

    logic [acpu16_pkg::WORD_W-1:0]    mem [acpu16_pkg::MEM_WORDS];
    logic [acpu16_pkg::WORD_W-1:0]    mem_rdata_reg;
    logic [acpu16_pkg::ADDR_W-1:0]    mem_addr;
    logic [acpu16_pkg::WORD_W-1:0]    mem_wdata;

    logic [acpu16_pkg::SIZE_W-1:0]    mem_size_reg;
    logic [1:0]                       kind_reg;
    logic [acpu16_pkg::IN_ADDR_W-1:0] in_addr_reg;
    logic [acpu16_pkg::WORD_W-1:0]    in_data_reg;
    logic [3:0]                       instr_op_reg;
    logic [acpu16_pkg::PC_W-1:0]      pc_reg, pc_next;
    logic [acpu16_pkg::WORD_W-1:0]    acc_reg, acc_next;
    logic [1:0]                       st_reg;
    logic [acpu16_pkg::WORD_W-1:0]    rd_reg;
    logic                             fault_reg;
    logic [47:0]                      out_reg;

    logic [acpu16_pkg::PC_W-1:0]      size_ext;
    logic [acpu16_pkg::PC_W-1:0]      lim;
    logic [acpu16_pkg::PC_W-1:0]      pc_plus1;
    logic [acpu16_pkg::OPND_W-1:0]    opnd;

    assign size_ext = acpu16_pkg::PC_W'(mem_size_reg);
    assign lim      = (size_ext > acpu16_pkg::LIM_MAX) ? acpu16_pkg::LIM_MAX : size_ext;
    assign pc_plus1 = pc_reg + 1'b1;
    assign opnd     = mem_rdata_reg[acpu16_pkg::OPND_W-1:0];

    // status toward the controller
    assign stat.kind          = kind_reg;
    assign stat.run_ok        = (st_reg == acpu16_pkg::ST_OK);
    assign stat.in_addr_ok    = (acpu16_pkg::PC_W'(in_addr_reg) < lim);
    assign stat.pc_ok         = (pc_reg < lim);
    assign stat.fetch_op      = mem_rdata_reg[15:12];
    assign stat.fetch_opnd_ok = (acpu16_pkg::PC_W'(opnd) < lim);
    assign stat.instr_op      = instr_op_reg;
    assign stat.eff_ok        = (mem_rdata_reg < acpu16_pkg::WORD_W'(lim));
    assign stat.acc_neg       = acc_reg[acpu16_pkg::WORD_W-1];
    assign stat.acc_zero      = (acc_reg == '0);

    // memory port
    always_comb begin
        case (cmd.addr_sel)
            acpu16_pkg::AS_IN: mem_addr = acpu16_pkg::ADDR_W'(in_addr_reg);
            acpu16_pkg::AS_PC: mem_addr = acpu16_pkg::ADDR_W'(pc_reg);
            default:           mem_addr = acpu16_pkg::ADDR_W'(mem_rdata_reg);
        endcase
        case (cmd.wd_sel)
            acpu16_pkg::WS_IN:  mem_wdata = in_data_reg;
            acpu16_pkg::WS_ACC: mem_wdata = acc_reg;
            default:            mem_wdata = acpu16_pkg::WORD_W'(pc_plus1);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[mem_addr] <= mem_wdata;
        end else if (cmd.mem_rd) begin
            mem_rdata_reg <= mem[mem_addr];
        end
    end

    // machine register updates
    always_comb begin
        case (cmd.acc_op)
            acpu16_pkg::ACC_CLR: acc_next = '0;
            acpu16_pkg::ACC_IMM: acc_next = {{4{opnd[acpu16_pkg::OPND_W-1]}}, opnd};
            acpu16_pkg::ACC_MEM: acc_next = mem_rdata_reg;
            acpu16_pkg::ACC_ADD: acc_next = acc_reg + mem_rdata_reg;
            acpu16_pkg::ACC_SUB: acc_next = acc_reg - mem_rdata_reg;
            default:             acc_next = acc_reg;
        endcase
        case (cmd.pc_op)
            acpu16_pkg::PC_CLR:  pc_next = '0;
            acpu16_pkg::PC_INC:  pc_next = pc_plus1;
            acpu16_pkg::PC_OPND: pc_next = acpu16_pkg::PC_W'(opnd);
            acpu16_pkg::PC_CALL: pc_next = acpu16_pkg::PC_W'(opnd) + 1'b1;
            acpu16_pkg::PC_EFF:  pc_next = acpu16_pkg::PC_W'(mem_rdata_reg);
            default:             pc_next = pc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_size_reg <= acpu16_pkg::MEM_SIZE_RST;
            pc_reg       <= '0;
            acc_reg      <= '0;
            st_reg       <= acpu16_pkg::ST_OK;
        end else begin
            if (cfg_we) begin
                mem_size_reg <= cfg_wdata;
            end
            pc_reg  <= pc_next;
            acc_reg <= acc_next;
            if (cmd.st_we) begin
                st_reg <= cmd.st_val;
            end
        end
    end

    // item, instruction and result registers
    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            kind_reg    <= s_tuser;
            in_addr_reg <= s_tdata[10:0];
            in_data_reg <= s_tdata[26:11];
            rd_reg      <= '0;
            fault_reg   <= 1'b0;
        end else begin
            if (cmd.rd_load) begin
                rd_reg <= mem_rdata_reg;
            end
            if (cmd.fault_set) begin
                fault_reg <= 1'b1;
            end
        end
        if (cmd.instr_load) begin
            instr_op_reg <= mem_rdata_reg[15:12];
        end
        if (cmd.out_load) begin
            out_reg <= {fault_reg, rd_reg, acc_reg, pc_reg, st_reg};
        end
    end

    assign m_tdata = out_reg;

endmodule

>>> design/acpu16_ctrl.sv
// ----------------------------------------------------------------------------
// acpu16_ctrl
// controller: item sequencing, instruction decode and output handshake
// ----------------------------------------------------------------------------
module acpu16_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  acpu16_pkg::stat_t      stat,
    output acpu16_pkg::cmd_t       cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DISP   = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_FETCH  = 3'd3;
    localparam logic [2:0] S_OPER   = 3'd4;
    localparam logic [2:0] S_IND    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.in_load = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP: begin
                state_next = S_DONE;
                case (stat.kind)
                    acpu16_pkg::K_LOAD: begin
                        if (stat.in_addr_ok) begin
                            cmd.mem_wr   = 1'b1;
                            cmd.addr_sel = acpu16_pkg::AS_IN;
                            cmd.wd_sel   = acpu16_pkg::WS_IN;
                        end else begin
                            cmd.fault_set = 1'b1;
                        end
                    end
                    acpu16_pkg::K_START: begin
                        cmd.pc_op  = acpu16_pkg::PC_CLR;
                        cmd.acc_op = acpu16_pkg::ACC_CLR;
                        cmd.st_we  = 1'b1;
                        cmd.st_val = acpu16_pkg::ST_OK;
                    end
                    acpu16_pkg::K_EXEC: begin
                        if (stat.run_ok) begin
                            if (stat.pc_ok) begin
                                cmd.mem_rd   = 1'b1;
                                cmd.addr_sel = acpu16_pkg::AS_PC;
                                state_next   = S_FETCH;
                            end else begin
                                cmd.st_we  = 1'b1;
                                cmd.st_val = acpu16_pkg::ST_ADDRERR;
                            end
                        end
                    end
                    default: begin
                        if (stat.in_addr_ok) begin
                            cmd.mem_rd   = 1'b1;
                            cmd.addr_sel = acpu16_pkg::AS_IN;
                            state_next   = S_RDWAIT;
                        end else begin
                            cmd.fault_set = 1'b1;
                        end
                    end
                endcase
            end
            S_RDWAIT: begin
                cmd.rd_load = 1'b1;
                state_next  = S_DONE;
            end
            S_FETCH: begin
                cmd.instr_load = 1'b1;
                cmd.pc_op      = acpu16_pkg::PC_INC;
                state_next     = S_DONE;
                case (stat.fetch_op)
                    acpu16_pkg::OP_HALT: begin
                        cmd.pc_op  = acpu16_pkg::PC_HOLD;
                        cmd.st_we  = 1'b1;
                        cmd.st_val = acpu16_pkg::ST_HALTED;
                    end
                    acpu16_pkg::OP_LDI: begin
                        cmd.acc_op = acpu16_pkg::ACC_IMM;
                    end
                    acpu16_pkg::OP_JMP: begin
                        cmd.pc_op = acpu16_pkg::PC_OPND;
                    end
                    acpu16_pkg::OP_JN: begin
                        if (stat.acc_neg) begin
                            cmd.pc_op = acpu16_pkg::PC_OPND;
                        end
                    end
                    acpu16_pkg::OP_JZ: begin
                        if (stat.acc_zero) begin
                            cmd.pc_op = acpu16_pkg::PC_OPND;
                        end
                    end
                    acpu16_pkg::OP_LD, acpu16_pkg::OP_LDX, acpu16_pkg::OP_ST,
                    acpu16_pkg::OP_STX, acpu16_pkg::OP_ADD, acpu16_pkg::OP_SUB,
                    acpu16_pkg::OP_JIND, acpu16_pkg::OP_CALL: begin
                        cmd.addr_sel = acpu16_pkg::AS_RD;
                        if (!stat.fetch_opnd_ok) begin
                            cmd.st_we  = 1'b1;
                            cmd.st_val = acpu16_pkg::ST_ADDRERR;
                        end else if (stat.fetch_op == acpu16_pkg::OP_ST) begin
                            cmd.mem_wr = 1'b1;
                            cmd.wd_sel = acpu16_pkg::WS_ACC;
                        end else if (stat.fetch_op == acpu16_pkg::OP_CALL) begin
                            cmd.mem_wr = 1'b1;
                            cmd.wd_sel = acpu16_pkg::WS_PC;
                            cmd.pc_op  = acpu16_pkg::PC_CALL;
                        end else begin
                            cmd.mem_rd = 1'b1;
                            state_next = S_OPER;
                        end
                    end
                    default: begin
                        cmd.st_we  = 1'b1;
                        cmd.st_val = acpu16_pkg::ST_OPERR;
                    end
                endcase
            end
            S_OPER: begin
                state_next = S_DONE;
                case (stat.instr_op)
                    acpu16_pkg::OP_LD:  cmd.acc_op = acpu16_pkg::ACC_MEM;
                    acpu16_pkg::OP_ADD: cmd.acc_op = acpu16_pkg::ACC_ADD;
                    acpu16_pkg::OP_SUB: cmd.acc_op = acpu16_pkg::ACC_SUB;
                    default: begin
                        cmd.addr_sel = acpu16_pkg::AS_RD;
                        cmd.wd_sel   = acpu16_pkg::WS_ACC;
                        if (!stat.eff_ok) begin
                            cmd.st_we  = 1'b1;
                            cmd.st_val = acpu16_pkg::ST_ADDRERR;
                        end else if (stat.instr_op == acpu16_pkg::OP_JIND) begin
                            cmd.pc_op = acpu16_pkg::PC_EFF;
                        end else if (stat.instr_op == acpu16_pkg::OP_STX) begin
                            cmd.mem_wr = 1'b1;
                        end else begin
                            cmd.mem_rd = 1'b1;
                            state_next = S_IND;
                        end
                    end
                endcase
            end
            S_IND: begin
                cmd.acc_op = acpu16_pkg::ACC_MEM;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

>>> design/accumulator_cpu16_step.sv
// ----------------------------------------------------------------------------
// accumulator_cpu16_step
// 16-bit accumulator machine driven one item at a time
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one item: load word, start machine, execute one
//   instruction or read word (kind on s_tuser). m_ channel returns exactly
//   one result per item: run status, pc, accumulator, read word, fault.
//   cfg_we/cfg_wdata set the number of memory words in use (reset 128);
//   the user must write them only while no item is in flight; not enforced.
// timing:
//   one item at a time; s_tready is high only when no item is in work.
//   load word and start go from dispatch straight to the result step;
//   read word adds a wait for the word, and execute adds fetch, operand
//   read and indirect read as needed, each on the single-port word memory.
// reset:
//   pc, accumulator and status clear, size in use returns to 128, the
//   word memory keeps no defined contents.
// stall:
//   a held result sits in the output register; the next item may be
//   accepted and worked, and waits in its final step until the output
//   register frees.
// ----------------------------------------------------------------------------
module accumulator_cpu16_step (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // address[10:0], data[26:11], zero[31:27]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], program_counter[14:2],
                                   // accumulator[30:15], read_word[46:31],
                                   // access_fault[47]
);

    acpu16_pkg::cmd_t  cmd;
    acpu16_pkg::stat_t stat;

    acpu16_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    acpu16_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata)
    );

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while another is in work");

    a_fault_no_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[47]) |-> (m_tdata[46:31] == '0))
        else $error("faulted access returned a word");

    a_one_port: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_wr |-> !cmd.mem_rd)
        else $error("memory read and write in one cycle");

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result overwrote a waiting result");

endmodule

>>> sim/accumulator_cpu16_step_tb.sv
// ----------------------------------------------------------------------------
// accumulator_cpu16_step_tb
// self-checking bench for the 16-bit accumulator machine: a short table of
// hand-picked items, then random programs and noise under several memory
// sizes, with bursty input, a stalling result side and a scoreboard fed by
// an independent model of the machine
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module accumulator_cpu16_step_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF       = 400;
    localparam int HOLD_AT        = 300;
    localparam int PHASE_ITEMS    = 100;
    localparam int SETTLE         = 8;

    localparam logic [3:0] OP_BAD_MIN = acpu16_pkg::OP_HALT + 4'd1;
    localparam logic [3:0] OP_BAD_MAX = 4'd15;

    typedef struct packed {
        logic        access_fault;
        logic [15:0] read_word;
        logic [15:0] accumulator;
        logic [12:0] program_counter;
        logic [1:0]  status;
    } result_t;

    typedef struct {
        logic [1:0]  kind;
        logic [10:0] addr;
        logic [15:0] data;
        bit          typed;
        result_t     res;
    } stim_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [11:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;

    // machine model state
    bit [15:0]   mem_words   [0:acpu16_pkg::MEM_WORDS-1];
    bit          mem_written [0:acpu16_pkg::MEM_WORDS-1];
    bit [12:0]   pc_q;
    bit [15:0]   acc_q;
    bit [1:0]    run_st;
    bit [11:0]   size_reg = acpu16_pkg::MEM_SIZE_RST;

    result_t     step_outcome_q[$];
    stim_row_t   directed_rows[$];
    int          phase_sizes [0:10];
    int          n_errors     = 0;
    int          results_seen = 0;
    int          stall_cycles = 0;
    int          burst_left   = 0;
    bit          no_gaps      = 1'b0;

    accumulator_cpu16_step i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int size_in_use();
        return (size_reg > acpu16_pkg::MEM_WORDS) ? acpu16_pkg::MEM_WORDS : int'(size_reg);
    endfunction

    function automatic void mem_write(input logic [10:0] a, input logic [15:0] v);
        mem_words[a]   = v;
        mem_written[a] = 1'b1;
    endfunction

    function automatic result_t machine_step(input logic [1:0] kind,
                                             input logic [10:0] addr,
                                             input logic [15:0] data);
        result_t   r;
        int        lim;
        bit [15:0] word;
        bit [3:0]  op;
        bit [11:0] opnd;
        bit [15:0] eff;
        lim = size_in_use();
        r = '0;
        case (kind)
            acpu16_pkg::K_LOAD: begin
                if (addr < lim) mem_write(addr, data);
                else r.access_fault = 1'b1;
            end
            acpu16_pkg::K_START: begin
                pc_q   = '0;
                acc_q  = '0;
                run_st = acpu16_pkg::ST_OK;
            end
            acpu16_pkg::K_EXEC: begin
                if (run_st == acpu16_pkg::ST_OK) begin
                    if (pc_q >= lim) begin
                        run_st = acpu16_pkg::ST_ADDRERR;
                    end else begin
                        word = mem_words[pc_q[10:0]];
                        op   = word[15:12];
                        opnd = word[11:0];
                        pc_q = pc_q + 13'd1;
                        if (op == acpu16_pkg::OP_HALT) begin
                            run_st = acpu16_pkg::ST_HALTED;
                            pc_q   = pc_q - 13'd1;
                        end else if (op > acpu16_pkg::OP_HALT) begin
                            run_st = acpu16_pkg::ST_OPERR;
                        end else if (op == acpu16_pkg::OP_LDI) begin
                            acc_q = {{4{opnd[11]}}, opnd};
                        end else if (op == acpu16_pkg::OP_JMP) begin
                            pc_q = 13'(opnd);
                        end else if (op == acpu16_pkg::OP_JN) begin
                            if (acc_q[15]) pc_q = 13'(opnd);
                        end else if (op == acpu16_pkg::OP_JZ) begin
                            if (acc_q == '0) pc_q = 13'(opnd);
                        end else if (opnd >= lim) begin
                            run_st = acpu16_pkg::ST_ADDRERR;
                        end else begin
                            case (op)
                                acpu16_pkg::OP_LD:
                                    acc_q = mem_words[opnd[10:0]];
                                acpu16_pkg::OP_ST:
                                    mem_write(opnd[10:0], acc_q);
                                acpu16_pkg::OP_ADD:
                                    acc_q = acc_q + mem_words[opnd[10:0]];
                                acpu16_pkg::OP_SUB:
                                    acc_q = acc_q - mem_words[opnd[10:0]];
                                acpu16_pkg::OP_CALL: begin
                                    mem_write(opnd[10:0], 16'(pc_q));
                                    pc_q = 13'(opnd) + 13'd1;
                                end
                                default: begin
                                    eff = mem_words[opnd[10:0]];
                                    if (eff >= lim)
                                        run_st = acpu16_pkg::ST_ADDRERR;
                                    else if (op == acpu16_pkg::OP_LDX)
                                        acc_q = mem_words[eff[10:0]];
                                    else if (op == acpu16_pkg::OP_STX)
                                        mem_write(eff[10:0], acc_q);
                                    else
                                        pc_q = 13'(eff);
                                end
                            endcase
                        end
                    end
                end
            end
            default: begin
                if (addr < lim) r.read_word = mem_words[addr];
                else r.access_fault = 1'b1;
            end
        endcase
        r.status          = run_st;
        r.program_counter = pc_q;
        r.accumulator     = acc_q;
        return r;
    endfunction

    // word the next instruction would read before it was ever written,
    // with a value to load there
    task automatic find_blank(output int blank, output logic [15:0] fill);
        int        lim;
        int        sel;
        bit [15:0] word;
        bit [3:0]  op;
        bit [11:0] opnd;
        bit [15:0] eff;
        lim   = size_in_use();
        blank = -1;
        fill  = 16'($urandom);
        if (run_st != acpu16_pkg::ST_OK || pc_q >= lim) return;
        if (!mem_written[pc_q[10:0]]) begin
            blank = int'(pc_q);
            sel   = $urandom_range(0, 99);
            if (sel < 88) op = 4'($urandom_range(acpu16_pkg::OP_LDI, acpu16_pkg::OP_CALL));
            else if (sel < 94) op = acpu16_pkg::OP_HALT;
            else op = 4'($urandom_range(OP_BAD_MIN, OP_BAD_MAX));
            opnd = ($urandom_range(0, 6) != 0) ? 12'($urandom_range(0, lim - 1))
                                               : 12'($urandom);
            fill = {op, opnd};
            return;
        end
        word = mem_words[pc_q[10:0]];
        op   = word[15:12];
        opnd = word[11:0];
        if ((op == acpu16_pkg::OP_LD || op == acpu16_pkg::OP_LDX ||
             op == acpu16_pkg::OP_STX || op == acpu16_pkg::OP_ADD ||
             op == acpu16_pkg::OP_SUB || op == acpu16_pkg::OP_JIND) && opnd < lim) begin
            if (!mem_written[opnd[10:0]]) begin
                blank = int'(opnd);
                if ((op == acpu16_pkg::OP_LDX || op == acpu16_pkg::OP_STX ||
                     op == acpu16_pkg::OP_JIND) && $urandom_range(0, 4) != 0)
                    fill = 16'($urandom_range(0, lim - 1));
            end else if (op == acpu16_pkg::OP_LDX) begin
                eff = mem_words[opnd[10:0]];
                if (eff < lim && !mem_written[eff[10:0]]) blank = int'(eff);
            end
        end
    endtask

    task automatic send_item(input logic [1:0] kind, input logic [10:0] addr,
                             input logic [15:0] data, input bit typed,
                             input result_t typed_res);
        int      gap;
        result_t pred;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (no_gaps) gap = 0;
            else if ($urandom_range(0, 3) == 0) gap = $urandom_range(10, 30);
            else gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, data, addr};
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = machine_step(kind, addr, data);
        step_outcome_q.push_back(typed ? typed_res : pred);
    endtask

    task automatic send_noise(output bit counted);
        logic [1:0]  kind;
        logic [10:0] addr;
        logic [15:0] fill;
        int          lim;
        int          blank;
        lim  = size_in_use();
        kind = 2'($urandom_range(acpu16_pkg::K_LOAD, acpu16_pkg::K_READ));
        addr = (lim > 0 && $urandom_range(0, 1) == 1) ? 11'($urandom_range(0, lim - 1))
                                                      : 11'($urandom);
        fill = 16'($urandom);
        if (kind == acpu16_pkg::K_READ && addr < lim && !mem_written[addr])
            kind = acpu16_pkg::K_LOAD;
        if (kind == acpu16_pkg::K_EXEC) begin
            find_blank(blank, fill);
            if (blank >= 0) begin
                kind = acpu16_pkg::K_LOAD;
                addr = 11'(blank);
            end
        end
        counted = !(kind == acpu16_pkg::K_EXEC && run_st != acpu16_pkg::ST_OK);
        send_item(kind, addr, fill, 1'b0, '0);
    endtask

    task automatic run_phase(input int quota);
        int          done_items;
        int          steps;
        int          blank;
        bit          counted;
        logic [15:0] fill;
        done_items = 0;
        no_gaps    = ($urandom_range(0, 3) == 0);
        while (done_items < quota) begin
            if ($urandom_range(0, 9) < 7) begin
                send_item(acpu16_pkg::K_START, 11'($urandom), 16'($urandom), 1'b0, '0);
                done_items++;
                steps = $urandom_range(4, 24);
                while (steps > 0 && run_st == acpu16_pkg::ST_OK) begin
                    find_blank(blank, fill);
                    if (blank >= 0) begin
                        send_item(acpu16_pkg::K_LOAD, 11'(blank), fill, 1'b0, '0);
                    end else if ($urandom_range(0, 9) == 0) begin
                        send_noise(counted);
                    end else begin
                        send_item(acpu16_pkg::K_EXEC, 11'($urandom), 16'($urandom),
                                  1'b0, '0);
                        steps--;
                    end
                    done_items++;
                end
                if (run_st != acpu16_pkg::ST_OK && $urandom_range(0, 1) == 1)
                    send_item(acpu16_pkg::K_EXEC, 11'($urandom), 16'($urandom), 1'b0, '0);
            end else begin
                send_noise(counted);
                if (counted) done_items++;
            end
        end
    endtask

    task automatic wait_idle(input int extra);
        s_tvalid <= 1'b0;
        while (step_outcome_q.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic set_mem_size(input logic [11:0] value);
        wait_idle(SETTLE);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        size_reg   = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_row(input logic [1:0] kind, input int addr, input int data,
                           input bit typed, input logic [1:0] st, input int pc,
                           input int acc, input int rd, input bit fault);
        stim_row_t row;
        row.kind                = kind;
        row.addr                = 11'(addr);
        row.data                = 16'(data);
        row.typed               = typed;
        row.res.status          = st;
        row.res.program_counter = 13'(pc);
        row.res.accumulator     = 16'(acc);
        row.res.read_word       = 16'(rd);
        row.res.access_fault    = fault;
        directed_rows.push_back(row);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_errors++;
        end
    endtask

    initial begin : stimulus
        phase_sizes    = '{4095, 40, 1, 0, 2048, 16, 2047, 300, 128, 0, 64};
        phase_sizes[9] = $urandom_range(1, acpu16_pkg::MEM_WORDS);

        // kind, addr, data
        //     chk, status, pc, acc, rd, flt
        add_row(acpu16_pkg::K_START, 0, 0,
                1'b1, acpu16_pkg::ST_OK, 0, 0, 0, 1'b0);
        add_row(acpu16_pkg::K_READ, 2047, 0,
                1'b1, acpu16_pkg::ST_OK, 0, 0, 0, 1'b1);
        add_row(acpu16_pkg::K_LOAD, 2047, 16'hFFFF,
                1'b1, acpu16_pkg::ST_OK, 0, 0, 0, 1'b1);
        add_row(acpu16_pkg::K_LOAD, 127, 16'hF801,
                1'b0, acpu16_pkg::ST_OK, 0, 0, 0, 1'b0);
        add_row(acpu16_pkg::K_LOAD, 0, {acpu16_pkg::OP_LDI, 12'h7FF},
                1'b0, acpu16_pkg::ST_OK, 0, 0, 0, 1'b0);
        add_row(acpu16_pkg::K_LOAD, 1, {acpu16_pkg::OP_ADD, 12'd127},
                1'b0, acpu16_pkg::ST_OK, 0, 0, 0, 1'b0);
        add_row(acpu16_pkg::K_LOAD, 2, {acpu16_pkg::OP_JZ, 12'd4},
                1'b0, acpu16_pkg::ST_OK, 0, 0, 0, 1'b0);
        add_row(acpu16_pkg::K_LOAD, 4, {OP_BAD_MAX, 12'hFFF},
                1'b0, acpu16_pkg::ST_OK, 0, 0, 0, 1'b0);
        add_row(acpu16_pkg::K_EXEC, 0, 0,
                1'b1, acpu16_pkg::ST_OK, 1, 16'h07FF, 0, 1'b0);
        add_row(acpu16_pkg::K_EXEC, 0, 0,
                1'b1, acpu16_pkg::ST_OK, 2, 0, 0, 1'b0);
        add_row(acpu16_pkg::K_EXEC, 0, 0,
                1'b0, acpu16_pkg::ST_OK, 0, 0, 0, 1'b0);
        add_row(acpu16_pkg::K_EXEC, 0, 0,
                1'b1, acpu16_pkg::ST_OPERR, 5, 0, 0, 1'b0);
        add_row(acpu16_pkg::K_EXEC, 0, 0,
                1'b1, acpu16_pkg::ST_OPERR, 5, 0, 0, 1'b0);
        add_row(acpu16_pkg::K_READ, 127, 0,
                1'b1, acpu16_pkg::ST_OPERR, 5, 0, 16'hF801, 1'b0);
        add_row(acpu16_pkg::K_LOAD, 0, {acpu16_pkg::OP_JMP, 12'd5},
                1'b0, acpu16_pkg::ST_OK, 0, 0, 0, 1'b0);
        add_row(acpu16_pkg::K_LOAD, 5, {acpu16_pkg::OP_LDI, 12'h800},
                1'b0, acpu16_pkg::ST_OK, 0, 0, 0, 1'b0);
        add_row(acpu16_pkg::K_LOAD, 6, {acpu16_pkg::OP_LD, 12'd128},
                1'b0, acpu16_pkg::ST_OK, 0, 0, 0, 1'b0);
        add_row(acpu16_pkg::K_START, 0, 0,
                1'b1, acpu16_pkg::ST_OK, 0, 0, 0, 1'b0);
        add_row(acpu16_pkg::K_EXEC, 0, 0,
                1'b0, acpu16_pkg::ST_OK, 0, 0, 0, 1'b0);
        add_row(acpu16_pkg::K_EXEC, 0, 0,
                1'b1, acpu16_pkg::ST_OK, 6, 16'hF800, 0, 1'b0);
        add_row(acpu16_pkg::K_EXEC, 0, 0,
                1'b1, acpu16_pkg::ST_ADDRERR, 7, 16'hF800, 0, 1'b0);
        add_row(acpu16_pkg::K_LOAD, 0, {acpu16_pkg::OP_HALT, 12'd0},
                1'b0, acpu16_pkg::ST_OK, 0, 0, 0, 1'b0);
        add_row(acpu16_pkg::K_START, 0, 0,
                1'b1, acpu16_pkg::ST_OK, 0, 0, 0, 1'b0);
        add_row(acpu16_pkg::K_EXEC, 0, 0,
                1'b1, acpu16_pkg::ST_HALTED, 0, 0, 0, 1'b0);
        add_row(acpu16_pkg::K_LOAD, 0, {acpu16_pkg::OP_JIND, 12'd3},
                1'b0, acpu16_pkg::ST_OK, 0, 0, 0, 1'b0);
        add_row(acpu16_pkg::K_LOAD, 3, 16'h0080,
                1'b0, acpu16_pkg::ST_OK, 0, 0, 0, 1'b0);
        add_row(acpu16_pkg::K_START, 0, 0,
                1'b0, acpu16_pkg::ST_OK, 0, 0, 0, 1'b0);
        add_row(acpu16_pkg::K_EXEC, 0, 0,
                1'b1, acpu16_pkg::ST_ADDRERR, 1, 0, 0, 1'b0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        foreach (directed_rows[r])
            send_item(directed_rows[r].kind, directed_rows[r].addr, directed_rows[r].data,
                      directed_rows[r].typed, directed_rows[r].res);

        foreach (phase_sizes[p]) begin
            set_mem_size(12'(phase_sizes[p]));
            run_phase(PHASE_ITEMS);
        end

        wait_idle(20);
        if (n_errors == 0) begin
            $display("accumulator_cpu16_step_tb OK");
        end else begin
            $display("accumulator_cpu16_step_tb NOT OK");
        end
        $finish;
    end

    initial begin : result_sink
        int ready_pct;
        int span;
        int sel;
        bit held;
        ready_pct = 100;
        span      = 0;
        held      = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && results_seen >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge aclk);
            end else begin
                if (span == 0) begin
                    sel       = $urandom_range(0, 2);
                    ready_pct = (sel == 0) ? 100 : ((sel == 1) ? 60 : 25);
                    span      = $urandom_range(16, 80);
                end
                span--;
                m_tready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            results_seen++;
            got = m_tdata;
            if (step_outcome_q.size() == 0) begin
                $error("result with no item pending: %h", m_tdata);
                n_errors++;
            end else begin
                want = step_outcome_q.pop_front();
                check_field("status", 16'(want.status), 16'(got.status));
                check_field("program_counter", 16'(want.program_counter),
                            16'(got.program_counter));
                check_field("accumulator", want.accumulator, got.accumulator);
                check_field("read_word", want.read_word, got.read_word);
                check_field("access_fault", 16'(want.access_fault),
                            16'(got.access_fault));
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("accumulator_cpu16_step_tb NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
